// File: design/cdt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdt_pkg: shared types and constants of the countdown alarm timer
// Holds the mode codes, register indexes, configuration and payload structs.
// ----------------------------------------------------------------------------
package cdt_pkg;

  // Widths of the configuration values
  localparam int DZ_W     = 12;
  localparam int PERIOD_W = 20;
  localparam int CFG_IDX_W = 3;

  // Operating modes, as shown on the mode output
  typedef enum logic [1:0] {
    MODE_IDLE      = 2'd0,
    MODE_PROGRAM   = 2'd1,
    MODE_COUNTDOWN = 2'd2,
    MODE_ALARM     = 2'd3
  } mode_t;

  // Field selection codes
  localparam logic [1:0] FIELD_HOURS   = 2'd0;
  localparam logic [1:0] FIELD_MINUTES = 2'd1;
  localparam logic [1:0] FIELD_SECONDS = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_LO      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_HI      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POLL_TICKS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_TICKS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TONE_TICKS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_TICKS  = 3'd5;

  // Reset values of the configuration registers
  localparam logic [DZ_W-1:0]     RST_ZONE_LO      = 12'd1000;
  localparam logic [DZ_W-1:0]     RST_ZONE_HI      = 12'd3500;
  localparam logic [PERIOD_W-1:0] RST_POLL_TICKS   = 20'd100000;
  localparam logic [PERIOD_W-1:0] RST_SECOND_TICKS = 20'd1000000;
  localparam logic [PERIOD_W-1:0] RST_TONE_TICKS   = 20'd125;
  localparam logic [PERIOD_W-1:0] RST_BLINK_TICKS  = 20'd250000;

  // Wrap limits of the time fields
  localparam logic [4:0] HOURS_MAX = 5'd23;
  localparam logic [5:0] MINSEC_MAX = 6'd59;

  typedef struct packed {
    logic [DZ_W-1:0]     zone_lo;
    logic [DZ_W-1:0]     zone_hi;
    logic [PERIOD_W-1:0] poll_ticks;
    logic [PERIOD_W-1:0] second_ticks;
    logic [PERIOD_W-1:0] tone_ticks;
    logic [PERIOD_W-1:0] blink_ticks;
  } cfg_t;

  typedef struct packed {
    logic        tick;
    logic [11:0] x_sample;
    logic [11:0] y_sample;
    logic        btn_a;
    logic        btn_b;
  } sample_t;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } hms_t;

  typedef struct packed {
    mode_t      mode;
    hms_t       shown;
    logic [1:0] field_selected;
    logic       buzzer_out;
    logic       led_out;
  } result_t;

endpackage

// File: design/cdt_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdt_cfg_regs: configuration register file
// Takes one register write per transfer; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module cdt_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [cdt_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [cdt_pkg::PERIOD_W-1:0]   wr_data,
  output cdt_pkg::cfg_t                  cfg
);
  import cdt_pkg::*;

  // Hold the registers, load on a write transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.zone_lo       <= RST_ZONE_LO;
      cfg.zone_hi       <= RST_ZONE_HI;
      cfg.poll_ticks    <= RST_POLL_TICKS;
      cfg.second_ticks  <= RST_SECOND_TICKS;
      cfg.tone_ticks    <= RST_TONE_TICKS;
      cfg.blink_ticks   <= RST_BLINK_TICKS;
    end else if (wr_en) begin
      case (wr_index)
        CFG_ZONE_LO:      cfg.zone_lo      <= wr_data[DZ_W-1:0];
        CFG_ZONE_HI:      cfg.zone_hi      <= wr_data[DZ_W-1:0];
        CFG_POLL_TICKS:   cfg.poll_ticks   <= wr_data;
        CFG_SECOND_TICKS: cfg.second_ticks <= wr_data;
        CFG_TONE_TICKS:   cfg.tone_ticks   <= wr_data;
        CFG_BLINK_TICKS:  cfg.blink_ticks  <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

// File: design/cdt_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdt_engine: timer state and single-pass update
// Applies one sample to the mode state, counters and time fields, and loads
// the result register with the state after the update.
// ----------------------------------------------------------------------------
module cdt_engine (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  cdt_pkg::sample_t smp,
  input  cdt_pkg::cfg_t    cfg,
  output cdt_pkg::result_t res
);
  import cdt_pkg::*;

  // Move the field selection one place, wrapping modulo three
  function automatic logic [1:0] field_move(input logic [1:0] f, input logic back);
    logic [1:0] r;
    case (f)
      FIELD_HOURS:   r = back ? FIELD_SECONDS : FIELD_MINUTES;
      FIELD_MINUTES: r = back ? FIELD_HOURS   : FIELD_SECONDS;
      FIELD_SECONDS: r = back ? FIELD_MINUTES : FIELD_HOURS;
      default:       r = back ? FIELD_SECONDS : FIELD_MINUTES;
    endcase
    return r;
  endfunction

  // Step hours up or down modulo 24
  function automatic logic [4:0] hours_move(input logic [4:0] v, input logic down);
    logic [4:0] r;
    if (down) r = (v == 5'd0) ? HOURS_MAX : v - 5'd1;
    else      r = (v >= HOURS_MAX) ? 5'd0 : v + 5'd1;
    return r;
  endfunction

  // Step minutes or seconds up or down modulo 60
  function automatic logic [5:0] minsec_move(input logic [5:0] v, input logic down);
    logic [5:0] r;
    if (down) r = (v == 6'd0) ? MINSEC_MAX : v - 6'd1;
    else      r = (v >= MINSEC_MAX) ? 6'd0 : v + 6'd1;
    return r;
  endfunction

  // Take one second off a non-zero time, borrowing across the fields
  function automatic hms_t hms_dec(input hms_t t);
    hms_t r;
    r = t;
    if (t.seconds != 6'd0) begin
      r.seconds = t.seconds - 6'd1;
    end else begin
      r.seconds = MINSEC_MAX;
      if (t.minutes != 6'd0) begin
        r.minutes = t.minutes - 6'd1;
      end else begin
        r.minutes = MINSEC_MAX;
        r.hours   = t.hours - 5'd1;
      end
    end
    return r;
  endfunction

  mode_t               mode_reg, mode_reg_next;
  logic [1:0]          selected_field, selected_field_next;
  hms_t                set_time, set_time_next;
  hms_t                remaining, remaining_next;
  logic                x_latched, x_latched_next;
  logic                y_latched, y_latched_next;
  logic [PERIOD_W-1:0] poll_counter, poll_counter_next;
  logic [PERIOD_W-1:0] second_counter, second_counter_next;
  logic [PERIOD_W-1:0] tone_counter, tone_counter_next;
  logic [PERIOD_W-1:0] blink_counter, blink_counter_next;
  logic                buzzer_level, buzzer_level_next;
  logic                led_level, led_level_next;

  logic [PERIOD_W-1:0] poll_inc, second_inc, tone_inc, blink_inc;
  logic                poll_hit, second_hit, tone_hit, blink_hit;
  logic                x_low, x_push, y_low, y_push;
  hms_t                rem_dec;

  // Period counters: count on a tick, hit when the period is reached
  assign poll_inc   = poll_counter + 1'b1;
  assign second_inc = second_counter + 1'b1;
  assign tone_inc   = tone_counter + 1'b1;
  assign blink_inc  = blink_counter + 1'b1;
  assign poll_hit   = smp.tick && (poll_inc >= cfg.poll_ticks);
  assign second_hit = smp.tick && (second_inc >= cfg.second_ticks);
  assign tone_hit   = smp.tick && (tone_inc >= cfg.tone_ticks);
  assign blink_hit  = smp.tick && (blink_inc >= cfg.blink_ticks);

  // Joystick deadzone: below low wins over above high
  assign x_low  = smp.x_sample < cfg.zone_lo;
  assign x_push = x_low || (smp.x_sample > cfg.zone_hi);
  assign y_low  = smp.y_sample < cfg.zone_lo;
  assign y_push = y_low || (smp.y_sample > cfg.zone_hi);

  assign rem_dec = hms_dec(remaining);

  // Next state for one sample
  always_comb begin
    mode_reg_next       = mode_reg;
    selected_field_next = selected_field;
    set_time_next       = set_time;
    remaining_next      = remaining;
    x_latched_next      = x_latched;
    y_latched_next      = y_latched;
    poll_counter_next   = poll_counter;
    second_counter_next = second_counter;
    tone_counter_next   = tone_counter;
    blink_counter_next  = blink_counter;
    buzzer_level_next   = buzzer_level;
    led_level_next      = led_level;

    case (mode_reg)
      MODE_IDLE: begin
        if (smp.btn_a) begin
          mode_reg_next     = MODE_PROGRAM;
          set_time_next     = '0;
          poll_counter_next = '0;
        end
      end

      MODE_PROGRAM: begin
        if (smp.tick) begin
          poll_counter_next = poll_hit ? '0 : poll_inc;
        end
        if (poll_hit) begin
          // X axis moves the selection, one step per push
          if (!x_push) begin
            x_latched_next = 1'b0;
          end else if (!x_latched) begin
            x_latched_next      = 1'b1;
            selected_field_next = field_move(selected_field, x_low);
          end
          // Y axis steps the newly selected field
          if (!y_push) begin
            y_latched_next = 1'b0;
          end else if (!y_latched) begin
            y_latched_next = 1'b1;
            case (selected_field_next)
              FIELD_HOURS:   set_time_next.hours   = hours_move(set_time.hours, y_low);
              FIELD_MINUTES: set_time_next.minutes = minsec_move(set_time.minutes, y_low);
              FIELD_SECONDS: set_time_next.seconds = minsec_move(set_time.seconds, y_low);
              default: ;
            endcase
          end
          // Button A leaves, button B starts a non-zero countdown
          if (smp.btn_a) begin
            mode_reg_next     = MODE_IDLE;
            buzzer_level_next = 1'b0;
            led_level_next    = 1'b0;
          end else if (smp.btn_b && (set_time_next != '0)) begin
            mode_reg_next       = MODE_COUNTDOWN;
            remaining_next      = set_time_next;
            second_counter_next = '0;
          end
        end
      end

      MODE_COUNTDOWN: begin
        if (smp.tick) begin
          second_counter_next = second_hit ? '0 : second_inc;
        end
        if (second_hit) begin
          if (remaining != '0) begin
            remaining_next = rem_dec;
          end
          if ((remaining == '0) || (rem_dec == '0)) begin
            mode_reg_next      = MODE_ALARM;
            buzzer_level_next  = 1'b0;
            led_level_next     = 1'b0;
            tone_counter_next  = '0;
            blink_counter_next = '0;
          end
        end
        if (smp.btn_a) begin
          mode_reg_next     = MODE_IDLE;
          buzzer_level_next = 1'b0;
          led_level_next    = 1'b0;
        end
      end

      default: begin
        // Alarm: toggle buzzer and LED at their own periods
        if (smp.tick) begin
          tone_counter_next  = tone_hit ? '0 : tone_inc;
          blink_counter_next = blink_hit ? '0 : blink_inc;
        end
        if (tone_hit) begin
          buzzer_level_next = !buzzer_level;
        end
        if (blink_hit) begin
          led_level_next = !led_level;
        end
        if (smp.btn_a) begin
          mode_reg_next     = MODE_IDLE;
          buzzer_level_next = 1'b0;
          led_level_next    = 1'b0;
        end
      end
    endcase
  end

  // Hold timer state, advance on each sample
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg       <= MODE_IDLE;
      selected_field <= FIELD_HOURS;
      set_time       <= '0;
      remaining      <= '0;
      x_latched      <= 1'b0;
      y_latched      <= 1'b0;
      poll_counter   <= '0;
      second_counter <= '0;
      tone_counter   <= '0;
      blink_counter  <= '0;
      buzzer_level   <= 1'b0;
      led_level      <= 1'b0;
    end else if (step) begin
      mode_reg       <= mode_reg_next;
      selected_field <= selected_field_next;
      set_time       <= set_time_next;
      remaining      <= remaining_next;
      x_latched      <= x_latched_next;
      y_latched      <= y_latched_next;
      poll_counter   <= poll_counter_next;
      second_counter <= second_counter_next;
      tone_counter   <= tone_counter_next;
      blink_counter  <= blink_counter_next;
      buzzer_level   <= buzzer_level_next;
      led_level      <= led_level_next;
    end
  end

  // Load the result register with the updated state
  always_ff @(posedge clk) begin
    if (step) begin
      res.mode           <= mode_reg_next;
      res.shown          <= ((mode_reg_next == MODE_COUNTDOWN) ||
                             (mode_reg_next == MODE_ALARM)) ? remaining_next : set_time_next;
      res.field_selected <= selected_field_next;
      res.buzzer_out     <= buzzer_level_next;
      res.led_out        <= led_level_next;
    end
  end

`ifndef ASSERT_OFF
  // A running countdown always has time left
  a_countdown_nonzero: assert property (@(posedge clk) disable iff (rst)
    (mode_reg == MODE_COUNTDOWN) |-> (remaining != '0))
    else $error("countdown running with zero time left");

  // The alarm is only reached with the time run out
  a_alarm_zero: assert property (@(posedge clk) disable iff (rst)
    (mode_reg == MODE_ALARM) |-> (remaining == '0))
    else $error("alarm with time left");

  // Buzzer and LED stay off outside the alarm
  a_levels_off: assert property (@(posedge clk) disable iff (rst)
    (mode_reg != MODE_ALARM) |-> (!buzzer_level && !led_level))
    else $error("buzzer or LED on outside alarm");

  // Idle only ever leads to program
  a_idle_exit: assert property (@(posedge clk) disable iff (rst)
    (step && (mode_reg == MODE_IDLE)) |=> ((mode_reg == MODE_IDLE) ||
                                           (mode_reg == MODE_PROGRAM)))
    else $error("idle left for a mode other than program");

  // The selection never holds the unused code
  a_field_range: assert property (@(posedge clk) disable iff (rst)
    selected_field != 2'd3)
    else $error("field selection out of range");
`endif

endmodule

// File: design/countdown_alarm_timer_controller_top.sv
`timescale 1ns / 1ps
// Path: a transferred sample waits in the input register until the result side is free,
//   then its result is loaded (two-stage path: input register, result register).
// Throughput: one sample per clock when not stalled; the update is a single pass of logic.
// Reset (rst, synchronous): idle mode, time and counters cleared, registers at
//   their default values; no clearing pass.
// ----------------------------------------------------------------------------
// countdown_alarm_timer_controller_top: countdown timer with alarm
// Input register and stall control around the timer engine and register file.
// ----------------------------------------------------------------------------
module countdown_alarm_timer_controller_top (
  input  logic                          clk,
  input  logic                          rst,
  // sample channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          tick,
  input  logic [11:0]                   x_sample,
  input  logic [11:0]                   y_sample,
  input  logic                          btn_a,
  input  logic                          btn_b,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    mode,
  output logic [4:0]                    shown_hours,
  output logic [5:0]                    shown_minutes,
  output logic [5:0]                    shown_seconds,
  output logic [1:0]                    field_selected,
  output logic                          buzzer_out,
  output logic                          led_out,
  // configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cdt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cdt_pkg::PERIOD_W-1:0]  cfg_data
);
  import cdt_pkg::*;

  cfg_t    cfg;
  sample_t smp;
  result_t res;
  logic    smp_valid;
  logic    out_free;
  logic    step;
  logic    in_take;

  assign cfg_ready = 1'b1;

  // Stall control: the result register frees when empty or taken
  assign out_free = !out_valid || !out_stall;
  assign step     = smp_valid && out_free;
  assign in_stall = smp_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      smp_valid <= 1'b0;
    end else if (in_take) begin
      smp_valid <= 1'b1;
    end else if (step) begin
      smp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      smp.tick     <= tick;
      smp.x_sample <= x_sample;
      smp.y_sample <= y_sample;
      smp.btn_a    <= btn_a;
      smp.btn_b    <= btn_b;
    end
  end

  // Result valid: set on a step, drop once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step;
    end
  end

  cdt_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  cdt_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .smp  (smp),
    .cfg  (cfg),
    .res  (res)
  );

  assign mode           = res.mode;
  assign shown_hours    = res.shown.hours;
  assign shown_minutes  = res.shown.minutes;
  assign shown_seconds  = res.shown.seconds;
  assign field_selected = res.field_selected;
  assign buzzer_out     = res.buzzer_out;
  assign led_out        = res.led_out;

endmodule

// File: tb/sv/countdown_alarm_timer_controller_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// countdown_alarm_timer_controller_top_tb: self-checking bench for the timer
// Drives joystick and button samples with random gaps, stalls the result side
// at random, and checks every display transfer against a cycle-free predictor
// of the idle / program / countdown / alarm behaviour. Configuration is
// rewritten between phases, covering zero, maximum and inverted settings.
// ----------------------------------------------------------------------------
module countdown_alarm_timer_controller_top_tb;
  import cdt_pkg::*;

  localparam int          STALL_LIMIT = 2000;
  localparam int          LONG_HOLD   = 60;
  localparam logic [11:0] AX_MIN      = 12'd0;
  localparam logic [11:0] AX_MID      = 12'd2048;
  localparam logic [11:0] AX_MAX      = 12'd4095;
  localparam logic [31:0] PERIOD_MAX  = 32'hFFFFF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        tick = 1'b0;
  logic [11:0] x_sample = '0;
  logic [11:0] y_sample = '0;
  logic        btn_a = 1'b0;
  logic        btn_b = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  mode;
  logic [4:0]  shown_hours;
  logic [5:0]  shown_minutes;
  logic [5:0]  shown_seconds;
  logic [1:0]  field_selected;
  logic        buzzer_out;
  logic        led_out;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [PERIOD_W-1:0]  cfg_data = '0;

  countdown_alarm_timer_controller_top DUT (.*);

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor copy of the timer state and its registers
  cfg_t        timer_cfg;
  mode_t       tm_mode = MODE_IDLE;
  logic [1:0]  tm_field = '0;
  logic [4:0]  set_h = '0;
  logic [5:0]  set_m = '0;
  logic [5:0]  set_s = '0;
  logic [16:0] remain = '0;
  logic        x_lock = 1'b0;
  logic        y_lock = 1'b0;
  logic [19:0] poll_cnt = '0;
  logic [19:0] sec_cnt = '0;
  logic [19:0] tone_cnt = '0;
  logic [19:0] blink_cnt = '0;
  logic        buzz = 1'b0;
  logic        led = 1'b0;

  result_t     pending_display[$];
  result_t     want;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  logic        send_gappy = 1'b1;
  logic        recv_gappy = 1'b1;
  logic        long_hold_req = 1'b0;

  typedef struct packed {
    sample_t s;
    logic    typed;
    result_t r;
  } bench_row_t;

  bench_row_t  bench_rows[$];

  // Advance a period counter by one tick: {elapsed, next count}
  function automatic logic [20:0] count_up(input logic [19:0] cnt, input logic [19:0] period);
    logic [19:0] nxt;
    nxt = cnt + 20'd1;
    if (nxt >= period) return {1'b1, 20'd0};
    return {1'b0, nxt};
  endfunction

  // -1 for a left/up push, +1 for right/down, 0 inside the deadzone
  function automatic int axis_dir(input logic [11:0] v);
    if (v < timer_cfg.zone_lo) return -1;
    if (v > timer_cfg.zone_hi) return 1;
    return 0;
  endfunction

  // Apply one accepted sample to the predictor and return the expected display
  function automatic result_t advance_timer(input sample_t s);
    logic [20:0] step;
    int          dx, dy, total, tmp, rem, hv, mv, sv;
    result_t     r;
    case (tm_mode)
      MODE_IDLE: begin
        if (s.btn_a) begin
          tm_mode  = MODE_PROGRAM;
          set_h    = '0;
          set_m    = '0;
          set_s    = '0;
          poll_cnt = '0;
        end
      end
      MODE_PROGRAM: begin
        if (s.tick) begin
          step     = count_up(poll_cnt, timer_cfg.poll_ticks);
          poll_cnt = step[19:0];
          if (step[20]) begin
            dx = axis_dir(s.x_sample);
            dy = axis_dir(s.y_sample);
            // X first, so Y acts on the newly selected field
            if (dx == 0) begin
              x_lock = 1'b0;
            end else if (!x_lock) begin
              x_lock   = 1'b1;
              tmp      = (int'(tm_field) + ((dx < 0) ? 2 : 1)) % 3;
              tm_field = tmp[1:0];
            end
            if (dy == 0) begin
              y_lock = 1'b0;
            end else if (!y_lock) begin
              y_lock = 1'b1;
              if (tm_field == FIELD_HOURS) begin
                tmp   = (int'(set_h) + ((dy < 0) ? 23 : 1)) % 24;
                set_h = tmp[4:0];
              end else if (tm_field == FIELD_MINUTES) begin
                tmp   = (int'(set_m) + ((dy < 0) ? 59 : 1)) % 60;
                set_m = tmp[5:0];
              end else if (tm_field == FIELD_SECONDS) begin
                tmp   = (int'(set_s) + ((dy < 0) ? 59 : 1)) % 60;
                set_s = tmp[5:0];
              end
            end
            total = int'(set_h) * 3600 + int'(set_m) * 60 + int'(set_s);
            // Button A wins over button B
            if (s.btn_a) begin
              tm_mode = MODE_IDLE;
              buzz    = 1'b0;
              led     = 1'b0;
            end else if (s.btn_b && total > 0) begin
              remain  = total[16:0];
              sec_cnt = '0;
              tm_mode = MODE_COUNTDOWN;
            end
          end
        end
      end
      MODE_COUNTDOWN: begin
        if (s.tick) begin
          step    = count_up(sec_cnt, timer_cfg.second_ticks);
          sec_cnt = step[19:0];
          if (step[20]) begin
            if (remain != '0) remain = remain - 17'd1;
            if (remain == '0) begin
              tm_mode   = MODE_ALARM;
              buzz      = 1'b0;
              led       = 1'b0;
              tone_cnt  = '0;
              blink_cnt = '0;
            end
          end
        end
        if (s.btn_a) begin
          tm_mode = MODE_IDLE;
          buzz    = 1'b0;
          led     = 1'b0;
        end
      end
      default: begin
        if (s.tick) begin
          step     = count_up(tone_cnt, timer_cfg.tone_ticks);
          tone_cnt = step[19:0];
          if (step[20]) buzz = !buzz;
          step      = count_up(blink_cnt, timer_cfg.blink_ticks);
          blink_cnt = step[19:0];
          if (step[20]) led = !led;
        end
        if (s.btn_a) begin
          tm_mode = MODE_IDLE;
          buzz    = 1'b0;
          led     = 1'b0;
        end
      end
    endcase

    // Remaining time while counting or ringing, set time otherwise
    if (tm_mode == MODE_COUNTDOWN || tm_mode == MODE_ALARM) begin
      rem = int'(remain);
      hv  = rem / 3600;
      mv  = (rem % 3600) / 60;
      sv  = rem % 60;
    end else begin
      hv = int'(set_h);
      mv = int'(set_m);
      sv = int'(set_s);
    end
    r.mode           = tm_mode;
    r.shown.hours    = hv[4:0];
    r.shown.minutes  = mv[5:0];
    r.shown.seconds  = sv[5:0];
    r.field_selected = tm_field;
    r.buzzer_out     = buzz;
    r.led_out        = led;
    return r;
  endfunction

  // Joystick sample inside, below or above the current deadzone
  function automatic logic [11:0] pick_axis();
    int          lo, hi;
    logic [31:0] v;
    lo = int'(timer_cfg.zone_lo);
    hi = int'(timer_cfg.zone_hi);
    v  = $urandom;
    case ($urandom_range(2, 0))
      0: if (lo <= hi) v = $urandom_range(hi, lo);
      1: if (lo > 0) v = $urandom_range(lo - 1, 0);
      default: if (hi < 4095) v = $urandom_range(4095, hi + 1);
    endcase
    return v[11:0];
  endfunction

  // Mostly purposeful samples for the predicted mode, some pure noise
  function automatic sample_t random_sample();
    sample_t     s;
    logic [31:0] v;
    v            = $urandom;
    s.tick       = v[0];
    s.x_sample   = v[12:1];
    s.y_sample   = v[24:13];
    s.btn_b      = v[25];
    s.btn_a      = ($urandom_range(15, 0) == 0);
    if ($urandom_range(7, 0) == 0) return s;
    s.tick     = ($urandom_range(7, 0) != 0);
    s.x_sample = pick_axis();
    s.y_sample = pick_axis();
    case (tm_mode)
      MODE_IDLE: s.btn_a = ($urandom_range(2, 0) == 0);
      MODE_PROGRAM: begin
        s.btn_a = ($urandom_range(39, 0) == 0);
        s.btn_b = ($urandom_range(5, 0) == 0);
      end
      MODE_COUNTDOWN: s.btn_a = ($urandom_range(149, 0) == 0);
      default: s.btn_a = ($urandom_range(11, 0) == 0);
    endcase
    return s;
  endfunction

  function automatic void stim_row(input logic t, input logic [11:0] x, input logic [11:0] y,
                                   input logic a, input logic b);
    bench_row_t row;
    row            = '0;
    row.s.tick     = t;
    row.s.x_sample = x;
    row.s.y_sample = y;
    row.s.btn_a    = a;
    row.s.btn_b    = b;
    bench_rows.push_back(row);
  endfunction

  function automatic void known_row(input logic t, input logic [11:0] x, input logic [11:0] y,
                                    input logic a, input logic b, input mode_t md,
                                    input logic [4:0] h, input logic [5:0] m,
                                    input logic [5:0] sc, input logic [1:0] f,
                                    input logic bz, input logic ld);
    bench_row_t row;
    stim_row(t, x, y, a, b);
    row                  = bench_rows.pop_back();
    row.typed            = 1'b1;
    row.r.mode           = md;
    row.r.shown.hours    = h;
    row.r.shown.minutes  = m;
    row.r.shown.seconds  = sc;
    row.r.field_selected = f;
    row.r.buzzer_out     = bz;
    row.r.led_out        = ld;
    bench_rows.push_back(row);
  endfunction

  // Offer one sample after a random gap; hold it until transferred
  task automatic send_sample(input sample_t s, input logic typed, input result_t typed_r);
    int      gap;
    result_t r;
    gap = send_gappy ? $urandom_range(5, 0) : 0;
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    tick     <= s.tick;
    x_sample <= s.x_sample;
    y_sample <= s.y_sample;
    btn_a    <= s.btn_a;
    btn_b    <= s.btn_b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = advance_timer(s);
    pending_display.push_back(typed ? typed_r : r);
  endtask

  // Write one register; the caller drops cfg_valid after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data[PERIOD_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_ZONE_LO:      timer_cfg.zone_lo      = data[DZ_W-1:0];
      CFG_ZONE_HI:      timer_cfg.zone_hi      = data[DZ_W-1:0];
      CFG_POLL_TICKS:   timer_cfg.poll_ticks   = data[PERIOD_W-1:0];
      CFG_SECOND_TICKS: timer_cfg.second_ticks = data[PERIOD_W-1:0];
      CFG_TONE_TICKS:   timer_cfg.tone_ticks   = data[PERIOD_W-1:0];
      CFG_BLINK_TICKS:  timer_cfg.blink_ticks  = data[PERIOD_W-1:0];
      default: ;
    endcase
  endtask

  // Drop the sample valid and drain every outstanding display
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_display.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic void cmp_field(input string name, input int unsigned exp_v,
                                    input int unsigned act_v);
    if (exp_v != act_v) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endfunction

  // Check each display transfer against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_display.size() == 0) begin
        mismatches++;
        $display("%0t: display transfer expected none, got mode %0d", $time, mode);
      end else begin
        want = pending_display.pop_front();
        cmp_field("mode", want.mode, mode);
        cmp_field("shown_hours", want.shown.hours, shown_hours);
        cmp_field("shown_minutes", want.shown.minutes, shown_minutes);
        cmp_field("shown_seconds", want.shown.seconds, shown_seconds);
        cmp_field("field_selected", want.field_selected, field_selected);
        cmp_field("buzzer_out", want.buzzer_out, buzzer_out);
        cmp_field("led_out", want.led_out, led_out);
      end
    end
  end

  // Watchdog: end the run after a long stretch with no transfer anywhere
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random stalls per transfer, one long hold on request
  initial begin : result_sink
    int hold;
    wait (rst == 1'b0);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold          = LONG_HOLD;
      end else begin
        hold = recv_gappy ? $urandom_range(5, 0) : 0;
      end
      repeat (hold) begin
        out_stall <= 1'b1;
        @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Stimulus
  initial begin : stimulus
    bench_row_t  row;
    int          phase, n;
    logic [31:0] lo_v, hi_v, poll_v, sec_v, tone_v, blink_v;

    timer_cfg.zone_lo      = RST_ZONE_LO;
    timer_cfg.zone_hi      = RST_ZONE_HI;
    timer_cfg.poll_ticks   = RST_POLL_TICKS;
    timer_cfg.second_ticks = RST_SECOND_TICKS;
    timer_cfg.tone_ticks   = RST_TONE_TICKS;
    timer_cfg.blink_ticks  = RST_BLINK_TICKS;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed walk: zero poll, second and tone periods act as one tick
    write_reg(CFG_ZONE_LO, 32'd1000);
    write_reg(CFG_ZONE_HI, 32'd3500);
    write_reg(CFG_POLL_TICKS, 32'd0);
    write_reg(CFG_SECOND_TICKS, 32'd0);
    write_reg(CFG_TONE_TICKS, 32'd0);
    write_reg(CFG_BLINK_TICKS, 32'd2);
    cfg_valid <= 1'b0;

    //        tick  x       y       A     B     mode            h  m  s  field bz led
    known_row(1'b1, AX_MID, AX_MID, 1'b0, 1'b0, MODE_IDLE,    0, 0, 0, 0, 0, 0);
    known_row(1'b1, AX_MID, AX_MID, 1'b0, 1'b1, MODE_IDLE,    0, 0, 0, 0, 0, 0);
    known_row(1'b0, AX_MID, AX_MID, 1'b1, 1'b0, MODE_PROGRAM, 0, 0, 0, 0, 0, 0);
    known_row(1'b0, AX_MID, AX_MIN, 1'b0, 1'b0, MODE_PROGRAM, 0, 0, 0, 0, 0, 0);
    known_row(1'b1, AX_MID, AX_MIN, 1'b0, 1'b0, MODE_PROGRAM, 23, 0, 0, 0, 0, 0);
    known_row(1'b1, AX_MID, AX_MIN, 1'b0, 1'b0, MODE_PROGRAM, 23, 0, 0, 0, 0, 0);
    known_row(1'b1, AX_MID, AX_MID, 1'b0, 1'b0, MODE_PROGRAM, 23, 0, 0, 0, 0, 0);
    known_row(1'b1, AX_MID, AX_MAX, 1'b0, 1'b0, MODE_PROGRAM, 0, 0, 0, 0, 0, 0);
    known_row(1'b1, AX_MAX, AX_MID, 1'b0, 1'b0, MODE_PROGRAM, 0, 0, 0, 1, 0, 0);
    // latched X, step minutes up then back down
    stim_row(1'b1, AX_MAX, AX_MAX, 1'b0, 1'b0);
    stim_row(1'b1, AX_MIN, AX_MID, 1'b0, 1'b0);
    stim_row(1'b1, AX_MID, AX_MIN, 1'b0, 1'b0);
    // wrap the selection left twice; Y acts on the new field
    stim_row(1'b1, AX_MIN, AX_MID, 1'b0, 1'b0);
    stim_row(1'b1, AX_MID, AX_MID, 1'b0, 1'b0);
    stim_row(1'b1, AX_MIN, AX_MAX, 1'b0, 1'b0);
    // start, reach alarm, toggle buzzer and LED, leave with A
    stim_row(1'b1, AX_MID, AX_MID, 1'b0, 1'b1);
    stim_row(1'b1, AX_MID, AX_MID, 1'b0, 1'b0);
    stim_row(1'b1, AX_MID, AX_MID, 1'b0, 1'b0);
    stim_row(1'b1, AX_MID, AX_MID, 1'b0, 1'b0);
    stim_row(1'b0, AX_MID, AX_MID, 1'b1, 1'b0);
    // A beats B in program; B with zero time does nothing
    stim_row(1'b1, AX_MID, AX_MID, 1'b1, 1'b0);
    stim_row(1'b1, AX_MID, AX_MID, 1'b1, 1'b1);
    stim_row(1'b0, AX_MID, AX_MID, 1'b1, 1'b0);
    stim_row(1'b1, AX_MID, AX_MID, 1'b0, 1'b1);
    stim_row(1'b1, AX_MID, AX_MAX, 1'b0, 1'b1);
    // A in the very item where the count reaches zero
    stim_row(1'b1, AX_MID, AX_MID, 1'b1, 1'b0);

    foreach (bench_rows[i]) begin
      row = bench_rows[i];
      send_sample(row.s, row.typed, row.r);
    end

    // Random phases, each under its own register setting
    for (phase = 0; phase < 8; phase++) begin
      settle();
      if (phase == 0) begin
        // inverted deadzone and zero periods
        lo_v = 32'd4095; hi_v = 32'd0;
        poll_v = 0; sec_v = 0; tone_v = 0; blink_v = 0;
      end else if (phase == 1) begin
        // widest deadzone, slowest periods
        lo_v = 32'd0; hi_v = 32'd4095;
        poll_v = PERIOD_MAX; sec_v = PERIOD_MAX; tone_v = PERIOD_MAX; blink_v = PERIOD_MAX;
      end else begin
        lo_v = $urandom_range(1800, 200);
        hi_v = $urandom_range(3900, 2200);
        if ($urandom_range(4, 0) == 0) begin
          lo_v = $urandom_range(4095, 0);
          hi_v = $urandom_range(4095, 0);
        end
        poll_v  = $urandom_range(4, 0);
        sec_v   = $urandom_range(6, 0);
        tone_v  = $urandom_range(3, 0);
        blink_v = $urandom_range(8, 0);
      end
      write_reg(CFG_ZONE_LO, lo_v);
      write_reg(CFG_ZONE_HI, hi_v);
      write_reg(CFG_POLL_TICKS, poll_v);
      write_reg(CFG_SECOND_TICKS, sec_v);
      write_reg(CFG_TONE_TICKS, tone_v);
      write_reg(CFG_BLINK_TICKS, blink_v);
      cfg_valid <= 1'b0;

      send_gappy = (phase % 3 != 2);
      recv_gappy = (phase % 4 != 3);
      // back-pressure: stream samples into a long result hold
      if (phase == 4) begin
        send_gappy    = 1'b0;
        long_hold_req = 1'b1;
      end
      n = (phase == 1) ? 60 : 250;
      repeat (n) send_sample(random_sample(), 1'b0, '0);
    end

    settle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
